FILE: src/osrb_pkg.sv
// Package for the overwriting sample ring buffer.
// Holds the ring depth, pointer widths, operation codes and transaction structs.
// No dependencies.
package osrb_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned PTR_W = IDX_W + 1;
  localparam int unsigned ENTRY_W = 96;
  localparam int unsigned FILL_W = 7;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GET   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_RESET = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] sample_value;
    logic [31:0] time_stamp_ms;
    logic [5:0]  peek_offset;
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] read_value;
    logic [31:0] read_stamp_ms;
    logic [6:0]  fill_count;
    logic        is_full;
    logic        is_empty;
  } result_t;

  // Status of one transaction, registered alongside the memory read.
  typedef struct packed {
    logic              valid;
    logic              ok;
    logic              rd;
    logic [FILL_W-1:0] fill;
    logic              full;
    logic              empty;
  } stage_t;

  // Memory request for the sample store.
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

endpackage

FILE: src/osrb_ram.sv
// Simple dual-port synchronous RAM, one write and one read port.
// Read data is registered. No package dependency.
module osrb_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/osrb_ctrl.sv
// Pointer control for the ring: decodes each command, updates the pointers,
// drives the memory request and registers the transaction status.
// Depends on osrb_pkg.
module osrb_ctrl import osrb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  cmd_t     cmd,
  output mem_req_t mem_req,
  output stage_t   stage
);

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [PTR_W-1:0] count;
  logic [PTR_W-1:0] count_next;
  logic             full;
  logic             ok_next;
  logic             rd_next;
  stage_t           stage_next;

  assign count = wr_ptr - rd_ptr;
  assign full  = (count == PTR_W'(DEPTH));

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    ok_next     = 1'b0;
    rd_next     = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = wr_ptr[IDX_W-1:0];
    mem_req.wdata = {cmd.sample_value, cmd.time_stamp_ms};
    mem_req.re    = 1'b0;
    mem_req.raddr = rd_ptr[IDX_W-1:0];
    case (op_t'(cmd.kind))
      OP_PUT: begin
        mem_req.we  = accept;
        wr_ptr_next = wr_ptr + PTR_W'(1);
        // full ring: drop the oldest entry
        if (full) begin
          rd_ptr_next = rd_ptr + PTR_W'(1);
        end
        ok_next = full;
      end
      OP_GET: begin
        if (count != '0) begin
          mem_req.re  = accept;
          rd_ptr_next = rd_ptr + PTR_W'(1);
          ok_next     = 1'b1;
          rd_next     = 1'b1;
        end
      end
      OP_PEEK: begin
        mem_req.raddr = rd_ptr[IDX_W-1:0] + IDX_W'(cmd.peek_offset);
        if (32'(cmd.peek_offset) < 32'(count)) begin
          mem_req.re = accept;
          ok_next    = 1'b1;
          rd_next    = 1'b1;
        end
      end
      OP_RESET: begin
        wr_ptr_next = '0;
        rd_ptr_next = '0;
      end
      default: begin
        wr_ptr_next = wr_ptr;
        rd_ptr_next = rd_ptr;
      end
    endcase

    count_next = wr_ptr_next - rd_ptr_next;
    stage_next.valid = accept;
    stage_next.ok    = ok_next;
    stage_next.rd    = rd_next;
    stage_next.fill  = FILL_W'(count_next);
    stage_next.full  = (count_next == PTR_W'(DEPTH));
    stage_next.empty = (count_next == '0);
  end

  always_ff @(posedge clk) begin
    stage.ok    <= stage_next.ok;
    stage.rd    <= stage_next.rd;
    stage.fill  <= stage_next.fill;
    stage.full  <= stage_next.full;
    stage.empty <= stage_next.empty;
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= stage_next.valid;
      if (accept) begin
        wr_ptr <= wr_ptr_next;
        rd_ptr <= rd_ptr_next;
      end
    end
  end

endmodule

FILE: src/overwriting_sample_ring_buffer.sv
// Top level of the overwriting sample ring buffer: pointer control, sample
// store RAM and the result register. Depends on osrb_pkg, osrb_ctrl, osrb_ram.
//
// A 64-entry ring of timestamped samples. A transaction is taken at every
// clock edge with start high (busy stays low), so one command per cycle is
// sustained. Its result passes the registered read of the sample store (with
// the status register) and then the result register, and is marked by done
// for a single cycle. The receiver cannot stall, so results must be
// captured when done is high. Pointers move at acceptance, so back-to-back
// commands always see the state left by the previous one; a read in the cycle
// after a put to the same entry gets the new data straight from the RAM.
// No clearing pass after reset: entries are only read after being written.
module overwriting_sample_ring_buffer import osrb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result
);

  logic               accept;
  mem_req_t           mem_req;
  stage_t             stage;
  logic [ENTRY_W-1:0] rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  osrb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .cmd     (cmd),
    .mem_req (mem_req),
    .stage   (stage)
  );

  osrb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    result.ok            <= stage.ok;
    result.read_value    <= stage.rd ? rdata[95:32] : 64'd0;
    result.read_stamp_ms <= stage.rd ? rdata[31:0] : 32'd0;
    result.fill_count    <= stage.fill;
    result.is_full       <= stage.full;
    result.is_empty      <= stage.empty;
  end

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("done without an accepted transaction two cycles earlier");

  a_fail_zero_data: assert property (@(posedge clk) disable iff (rst)
    (done && !result.ok) |-> (result.read_value == 64'd0 && result.read_stamp_ms == 32'd0))
    else $error("failed or non-read transaction returned nonzero data");

  a_empty_not_full: assert property (@(posedge clk) disable iff (rst)
    (done && result.is_empty) |-> (!result.is_full && result.fill_count == 7'd0))
    else $error("empty ring reported with nonzero fill or full flag");

endmodule
